FILE: src/mhe_pkg.sv
// ----------------------------------------------------------------------------
// mhe_pkg: shared types and constants of the min-heap timestamp evictor
// Entry layout, index widths, sequencer states and the sift-unit control.
// ----------------------------------------------------------------------------
package mhe_pkg;

  localparam int CAPACITY  = 7;
  localparam int KEY_WIDTH = 32;
  localparam int TAG_WIDTH = 16;
  localparam int OCC_WIDTH = 3;

  // Slot index and fill count widths.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Child indices can run past the last slot, so they get headroom.
  localparam int CHILD_W = IDX_W + 2;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [TAG_WIDTH-1:0] tag_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CHILD_W-1:0]   child_t;

  typedef struct packed {
    key_t key;
    tag_t tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_UP,
    ST_DOWN,
    ST_DONE
  } state_t;

  // Control into the sift unit.
  typedef struct packed {
    logic up;       // sift-up: swap when the moving entry is smaller
    logic b_valid;  // second candidate (right child) exists
  } sift_ctl_t;

  // Decision out of the sift unit.
  typedef struct packed {
    logic swap;
    logic take_b;
  } sift_res_t;

  function automatic idx_t parent_of(input idx_t pos);
    idx_t p;
    p = (pos - idx_t'(1)) >> 1;
    return p;
  endfunction

  function automatic child_t left_of(input idx_t pos);
    child_t c;
    c = child_t'({pos, 1'b0}) + child_t'(1);
    return c;
  endfunction

endpackage

FILE: src/mhe_ifs.sv
// ----------------------------------------------------------------------------
// mhe_ifs: transfer channels of the min-heap timestamp evictor
// Insert request channel and eviction report channel, valid/ready style.
// ----------------------------------------------------------------------------
interface mhe_in_if;
  import mhe_pkg::*;

  logic valid;
  logic ready;
  key_t new_key;
  tag_t new_tag;

  modport source (output valid, output new_key, output new_tag, input ready);
  modport sink   (input valid, input new_key, input new_tag, output ready);
endinterface

interface mhe_out_if;
  import mhe_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 evicted_valid;
  key_t                 evicted_key;
  tag_t                 evicted_tag;
  logic [OCC_WIDTH-1:0] occupancy;

  modport source (
    output valid, output evicted_valid, output evicted_key,
    output evicted_tag, output occupancy, input ready
  );
  modport sink (
    input valid, input evicted_valid, input evicted_key,
    input evicted_tag, input occupancy, output ready
  );
endinterface

FILE: src/mhe_ram.sv
// ----------------------------------------------------------------------------
// mhe_ram: generic RAM, one write port and two registered read ports
// Read data appears the cycle after the address is presented.
// ----------------------------------------------------------------------------
module mhe_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 4,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: src/mhe_sift_unit.sv
// ----------------------------------------------------------------------------
// mhe_sift_unit: shared compare unit for one heap level
// Picks the smaller child and decides whether the moving entry swaps.
// ----------------------------------------------------------------------------
module mhe_sift_unit (
  input  mhe_pkg::entry_t    cand_a,
  input  mhe_pkg::entry_t    cand_b,
  input  mhe_pkg::entry_t    moving,
  input  mhe_pkg::sift_ctl_t ctl,
  output mhe_pkg::entry_t    pick,
  output mhe_pkg::sift_res_t res
);
  import mhe_pkg::*;

  logic b_less;

  // The right child wins only when strictly smaller, so ties go left.
  assign b_less     = ctl.b_valid && (cand_b.key < cand_a.key);
  assign res.take_b = b_less;
  assign pick       = b_less ? cand_b : cand_a;

  // Strict compares in both directions keep equal keys in place.
  assign res.swap = ctl.up ? (moving.key < pick.key) : (pick.key < moving.key);

endmodule

FILE: src/min_heap_timestamp_evictor.sv
// ----------------------------------------------------------------------------
// min_heap_timestamp_evictor: fixed-capacity min-heap with root eviction
// Inserts timestamped entries; when full, reports and replaces the oldest.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Fields                                              | Role
//  --------+-----+-----------------------------------------------------+------------------
//  req     | in  | new_key, new_tag                                    | one insert
//  rsp     | out | evicted_valid, evicted_key, evicted_tag, occupancy  | one report
//
// Sequence: an insert into a heap that is not full climbs from the first free
// slot in ST_UP, then waits in ST_DONE until its report is loaded into the
// output register, and ST_IDLE then takes the next request. An insert into a
// full heap reads the root in ST_ROOT and sinks the new root in ST_DOWN before
// ST_DONE. With seven slots an entry climbs or sinks at most two levels.
// The heap RAM's registered read serves one tree level per cycle, and the
// sequencer walks the levels one by one.
// Reset: the fill count and all control state clear; heap slots hold whatever
// they held and are only read once written.
// Stalls: a report waits in the output register while rsp is held off; the next
// request is taken meanwhile and only its final step waits for the register.
//
module min_heap_timestamp_evictor (
  input  logic clk,
  input  logic rst,
  mhe_in_if.sink    req,
  mhe_out_if.source rsp
);
  import mhe_pkg::*;

  // Sequencer and heap bookkeeping.
  state_t state, state_next;
  cnt_t   fill;
  idx_t   pos, pos_next;
  entry_t moving;      // entry being inserted, it travels through the tree
  entry_t evicted;     // old root, zero when nothing is evicted
  logic   evict_flag;
  logic   sift_done;

  // Output register.
  logic                 out_valid;
  logic                 out_evicted_valid;
  key_t                 out_evicted_key;
  tag_t                 out_evicted_tag;
  logic [OCC_WIDTH-1:0] out_occupancy;

  // Heap memory ports.
  logic   ram_we;
  idx_t   ram_waddr, ram_raddr_a, ram_raddr_b;
  entry_t ram_wdata, ram_rdata_a, ram_rdata_b;

  // Sift unit.
  sift_ctl_t sift_ctl;
  sift_res_t sift_res;
  entry_t    sift_pick;

  logic   full;
  logic   req_xfer;
  logic   out_free;
  child_t left_c, right_c, pick_left;
  logic   left_ok, right_ok;
  idx_t   pick_idx;

  assign full     = (fill == cnt_t'(CAPACITY));
  assign req_xfer = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  // Children of the current slot. The sink path only runs on a full heap, so
  // a child exists exactly when its index is below the capacity.
  assign left_c   = left_of(pos);
  assign right_c  = left_c + child_t'(1);
  assign left_ok  = (left_c < child_t'(CAPACITY));
  assign right_ok = (right_c < child_t'(CAPACITY));
  assign pick_idx = sift_res.take_b ? idx_t'(right_c) : idx_t'(left_c);
  assign pick_left = left_of(pick_idx);

  mhe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY),
    .ADDR_W(IDX_W)
  ) u_heap (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr_a(ram_raddr_a),
    .raddr_b(ram_raddr_b),
    .rdata_a(ram_rdata_a),
    .rdata_b(ram_rdata_b)
  );

  // In the climb, port A carries the parent; in the sink, A and B carry the
  // left and right children.
  assign sift_ctl.up      = (state == ST_UP);
  assign sift_ctl.b_valid = (state == ST_DOWN) && right_ok;

  mhe_sift_unit u_sift (
    .cand_a(ram_rdata_a),
    .cand_b(ram_rdata_b),
    .moving(moving),
    .ctl   (sift_ctl),
    .pick  (sift_pick),
    .res   (sift_res)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_xfer) begin
          state_next = full ? ST_ROOT : ST_UP;
        end
      end
      ST_ROOT: state_next = ST_DOWN;
      ST_UP, ST_DOWN: begin
        if (sift_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory addressing and the per-level move. Every step writes at most one
  // slot: either the entry that moves toward the moving one's old place, or
  // the moving entry itself once it has settled.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = pos;
    ram_wdata   = moving;
    ram_raddr_a = '0;
    ram_raddr_b = '0;
    pos_next    = pos;
    sift_done   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (full) begin
          ram_raddr_a = '0;
          pos_next    = '0;
        end else begin
          // The new entry starts in the first free slot.
          pos_next    = idx_t'(fill);
          ram_raddr_a = (fill == '0) ? '0 : parent_of(idx_t'(fill));
        end
      end
      ST_ROOT: begin
        ram_raddr_a = idx_t'(1);
        ram_raddr_b = idx_t'(2);
      end
      ST_UP: begin
        ram_we = 1'b1;
        if ((pos != '0) && sift_res.swap) begin
          // Parent moves down into the current slot.
          ram_wdata   = ram_rdata_a;
          pos_next    = parent_of(pos);
          ram_raddr_a = parent_of(parent_of(pos));
        end else begin
          sift_done = 1'b1;
        end
      end
      ST_DOWN: begin
        ram_we = 1'b1;
        if (left_ok && sift_res.swap) begin
          // Smaller child moves up into the current slot.
          ram_wdata   = sift_pick;
          pos_next    = pick_idx;
          ram_raddr_a = idx_t'(pick_left);
          ram_raddr_b = idx_t'(pick_left + child_t'(1));
        end else begin
          sift_done = 1'b1;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= '0;
      evict_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (req_xfer) begin
        evict_flag <= full;
        if (!full) begin
          fill <= fill + cnt_t'(1);
        end
      end
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pos <= pos_next;
    if (req_xfer) begin
      moving.key <= req.new_key;
      moving.tag <= req.new_tag;
      evicted    <= '0;
    end
    if (state == ST_ROOT) begin
      evicted <= ram_rdata_a;
    end
    if ((state == ST_DONE) && out_free) begin
      out_evicted_valid <= evict_flag;
      out_evicted_key   <= evicted.key;
      out_evicted_tag   <= evicted.tag;
      out_occupancy     <= OCC_WIDTH'(fill);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.evicted_valid = out_evicted_valid;
  assign rsp.evicted_key   = out_evicted_key;
  assign rsp.evicted_tag   = out_evicted_tag;
  assign rsp.occupancy     = out_occupancy;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the min-heap timestamp evictor
// Drives directed and random inserts with random idling on both channels,
// predicts each report from typed rows or a shadow heap, checks every field.
// ----------------------------------------------------------------------------
module tb;
  import mhe_pkg::*;

  // One report as the block presents it on the output channel.
  typedef struct packed {
    logic                 evicted;
    key_t                 key;
    tag_t                 tag;
    logic [OCC_WIDTH-1:0] occ;
  } eviction_report_t;

  // One row of the directed table. Rows with a typed-in report are checked
  // against that report; the others fall back to the shadow heap.
  typedef struct packed {
    key_t             key;
    tag_t             tag;
    logic             typed;
    eviction_report_t want;
  } stim_row_t;

  // Stall styles of the report receiver.
  typedef enum int {
    RX_FREE,
    RX_MOSTLY,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  localparam int DIRECTED_N = 14;
  localparam int RANDOM_N   = 1836;

  logic clk;
  logic rst;

  mhe_in_if  insert_ch ();
  mhe_out_if report_ch ();

  min_heap_timestamp_evictor dut (
    .clk (clk),
    .rst (rst),
    .req (insert_ch),
    .rsp (report_ch)
  );

  // Shadow copy of the heap, updated once for every insert transfer.
  key_t shadow_keys [CAPACITY];
  tag_t shadow_tags [CAPACITY];
  int   shadow_fill;

  // Reports still owed by the block, oldest first.
  eviction_report_t pending_reports [$];

  int        mismatches;
  int        inserts_accepted;
  int        burst_left;
  key_t      clock_now;
  logic      row_typed;
  eviction_report_t row_want;
  stim_row_t directed_rows [DIRECTED_N];

  // --------------------------------------------------------------------------
  // Clock, and the one and only reset at the start of the run.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The run is cut off here if the block ever hangs.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shadow heap. A slot exchange moves key and tag together.
  // --------------------------------------------------------------------------
  function automatic void swap_slots(input int a, input int b);
    key_t k;
    tag_t t;
    k = shadow_keys[a];
    t = shadow_tags[a];
    shadow_keys[a] = shadow_keys[b];
    shadow_tags[a] = shadow_tags[b];
    shadow_keys[b] = k;
    shadow_tags[b] = t;
  endfunction

  // Inserts one entry into the shadow heap and returns the report the block
  // must give for it. Below capacity the entry is appended and climbs while
  // strictly smaller than its parent. At capacity the root is evicted, the new
  // entry takes its place and sinks toward the smaller child, the left one on
  // a tie, again only while that child is strictly smaller. Equal keys never
  // swap.
  function automatic eviction_report_t predict_insert(input key_t key, input tag_t tag);
    eviction_report_t r;
    int               pos;
    int               lc;
    int               rc;
    int               pick;
    bit               settled;
    r = '0;
    if (shadow_fill < CAPACITY) begin
      pos = shadow_fill;
      shadow_keys[pos] = key;
      shadow_tags[pos] = tag;
      shadow_fill++;
      settled = 1'b0;
      while (pos > 0 && !settled) begin
        if (shadow_keys[pos] < shadow_keys[(pos - 1) / 2]) begin
          swap_slots(pos, (pos - 1) / 2);
          pos = (pos - 1) / 2;
        end else begin
          settled = 1'b1;
        end
      end
    end else begin
      r.evicted = 1'b1;
      r.key = shadow_keys[0];
      r.tag = shadow_tags[0];
      shadow_keys[0] = key;
      shadow_tags[0] = tag;
      pos = 0;
      settled = 1'b0;
      while (!settled) begin
        lc = 2 * pos + 1;
        rc = lc + 1;
        if (lc >= shadow_fill) begin
          settled = 1'b1;
        end else begin
          pick = lc;
          if (rc < shadow_fill && shadow_keys[rc] < shadow_keys[lc]) begin
            pick = rc;
          end
          if (shadow_keys[pick] < shadow_keys[pos]) begin
            swap_slots(pos, pick);
            pos = pick;
          end else begin
            settled = 1'b1;
          end
        end
      end
    end
    r.occ = shadow_fill[OCC_WIDTH-1:0];
    return r;
  endfunction

  // Prints one line per mismatch and counts all of them.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: bad %s: got %h, expected %h", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Monitor. Both channels are sampled at the rising edge, the same edge at
  // which the block sees a transfer. An insert and its report can never meet
  // in the same cycle, since the block loads a report only from its DONE state.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    eviction_report_t predicted;
    eviction_report_t want;
    if (!rst) begin
      if (insert_ch.valid && insert_ch.ready) begin
        predicted = predict_insert(insert_ch.new_key, insert_ch.new_tag);
        pending_reports.push_back(row_typed ? row_want : predicted);
        inserts_accepted++;
      end
      if (report_ch.valid && report_ch.ready) begin
        if (pending_reports.size() == 0) begin
          report_mismatch("report with nothing pending", report_ch.evicted_key, '0);
        end else begin
          want = pending_reports.pop_front();
          if (report_ch.evicted_valid !== want.evicted) begin
            report_mismatch("evicted_valid", 32'(report_ch.evicted_valid),
                            32'(want.evicted));
          end
          if (report_ch.evicted_key !== want.key) begin
            report_mismatch("evicted_key", report_ch.evicted_key, want.key);
          end
          if (report_ch.evicted_tag !== want.tag) begin
            report_mismatch("evicted_tag", 32'(report_ch.evicted_tag), 32'(want.tag));
          end
          if (report_ch.occupancy !== want.occ) begin
            report_mismatch("occupancy", 32'(report_ch.occupancy), 32'(want.occ));
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Report receiver. It switches between stall styles at random intervals,
  // including stretches with no stall at all. Twice it holds off for a long
  // stretch while inserts keep coming, so the block's output register fills
  // and the insert channel backs up.
  // --------------------------------------------------------------------------
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       phase;
    bit       first_hold_done;
    bit       second_hold_done;
    mode = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    phase = 0;
    first_hold_done = 1'b0;
    second_hold_done = 1'b0;
    report_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      phase++;
      if (!first_hold_done && inserts_accepted >= 300) begin
        first_hold_done = 1'b1;
        hold_left = 120;
      end else if (!second_hold_done && inserts_accepted >= 1300) begin
        second_hold_done = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        report_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_FREE:     report_ch.ready <= 1'b1;
          RX_MOSTLY:   report_ch.ready <= ($urandom_range(0, 9) < 7);
          RX_PERIODIC: report_ch.ready <= (phase % 4 != 3);
          default:     report_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Insert sender. Items go out in bursts of random length; between bursts
  // valid drops for a random gap. A long burst now and then gives runs with
  // no idling. Inputs change only at the falling edge, and valid stays high
  // from one item to the next inside a burst.
  // --------------------------------------------------------------------------
  task automatic offer_insert(input key_t key, input tag_t tag, input logic typed,
                              input eviction_report_t want);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                              : $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        insert_ch.valid <= 1'b0;
      end
    end
    @(negedge clk);
    insert_ch.valid   <= 1'b1;
    insert_ch.new_key <= key;
    insert_ch.new_tag <= tag;
    row_typed = typed;
    row_want = want;
    do @(posedge clk); while (!insert_ch.ready);
    burst_left--;
  endtask

  // Drops valid and waits until every owed report has come back.
  task automatic drain_reports();
    @(negedge clk);
    insert_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  // Random keys. Half follow a last-access clock that only moves forward, in
  // small steps and often not at all, which is how the block is used: new
  // entries are young, sink all the way down, and ties are common. The rest
  // are tiny keys full of ties, the two extremes, and anything at all.
  function automatic key_t next_key();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      clock_now = clock_now + key_t'($urandom_range(0, 3));
      return clock_now;
    end else if (pick < 7) begin
      return key_t'($urandom_range(0, 7));
    end else if (pick == 7) begin
      return $urandom_range(0, 1) ? '1 : '0;
    end
    return key_t'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int   i;
    key_t key;
    tag_t tag;
    mismatches = 0;
    inserts_accepted = 0;
    burst_left = 0;
    shadow_fill = 0;
    row_typed = 1'b0;
    row_want = '0;
    clock_now = key_t'($urandom);
    for (i = 0; i < CAPACITY; i++) begin
      shadow_keys[i] = '0;
      shadow_tags[i] = '0;
    end
    insert_ch.valid = 1'b0;
    insert_ch.new_key = '0;
    insert_ch.new_tag = '0;

    // The first seven rows fill the heap from empty: each report carries no
    // eviction and the new fill count. The second zero key ties with the root
    // and must stay below it. The next two rows evict from a full heap: the
    // older of the two zero keys leaves first, then the younger one. The rest
    // mix extremes and ties and go through the shadow heap.
    directed_rows = '{
      '{32'h8000_0000, 16'h0001, 1'b1, '{1'b0, 32'h0, 16'h0, 3'd1}},
      '{32'h0000_0000, 16'hFFFF, 1'b1, '{1'b0, 32'h0, 16'h0, 3'd2}},
      '{32'hFFFF_FFFF, 16'h0000, 1'b1, '{1'b0, 32'h0, 16'h0, 3'd3}},
      '{32'h0000_0000, 16'h1234, 1'b1, '{1'b0, 32'h0, 16'h0, 3'd4}},
      '{32'h0000_0005, 16'h0005, 1'b1, '{1'b0, 32'h0, 16'h0, 3'd5}},
      '{32'h0000_0005, 16'h0006, 1'b1, '{1'b0, 32'h0, 16'h0, 3'd6}},
      '{32'h0000_0001, 16'h0007, 1'b1, '{1'b0, 32'h0, 16'h0, 3'd7}},
      '{32'h7FFF_FFFF, 16'hAAAA, 1'b1, '{1'b1, 32'h0, 16'hFFFF, 3'd7}},
      '{32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{1'b1, 32'h0, 16'h1234, 3'd7}},
      '{32'h0000_0001, 16'h0002, 1'b0, '0},
      '{32'h0000_0000, 16'h0000, 1'b0, '0},
      '{32'hFFFF_FFFF, 16'h0000, 1'b0, '0},
      '{32'h5A5A_5A5A, 16'h5A5A, 1'b0, '0},
      '{32'hA5A5_A5A5, 16'hA5A5, 1'b0, '0}
    };

    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_N; i++) begin
      offer_insert(directed_rows[i].key, directed_rows[i].tag,
                   directed_rows[i].typed, directed_rows[i].want);
    end
    drain_reports();

    for (i = 0; i < RANDOM_N; i++) begin
      // Halfway through, the sender stops until the block has caught up.
      if (i == RANDOM_N / 2) begin
        drain_reports();
      end
      key = next_key();
      tag = tag_t'($urandom);
      offer_insert(key, tag, 1'b0, '0);
    end

    @(negedge clk);
    insert_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    // Anything the block sends after the last owed report is caught here.
    repeat (16) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: min_heap_timestamp_evictor.f
src/mhe_pkg.sv
src/mhe_ifs.sv
src/mhe_ram.sv
src/mhe_sift_unit.sv
src/min_heap_timestamp_evictor.sv
dv/tb.sv
